/* src/gyro_tilt_compensated_cursor_assert.svh */
// Assertion macros for the tilt-compensated cursor block.
// Each macro is defined twice: as a concurrent assertion for simulation and as
// an empty body when SYNTHESIS is defined.
`ifndef GYRO_TILT_COMPENSATED_CURSOR_ASSERT_SVH
`define GYRO_TILT_COMPENSATED_CURSOR_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge out of reset.
`define GTC_ASSERT_IMP(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("gtc assertion failed");
// Next-cycle implication, checked at every rising edge out of reset.
`define GTC_ASSERT_NXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("gtc assertion failed");
`else
`define GTC_ASSERT_IMP(label, ck, rn, ante, cons)
`define GTC_ASSERT_NXT(label, ck, rn, ante, cons)
`endif
`endif

/* src/gtc_pkg.sv */
`timescale 1ns / 1ps

package gtc_pkg;

  localparam int ANGLE_WIDTH_DEF = 16;
  localparam int TABLE_LEN       = 24;
  localparam int ITER_W          = $clog2(TABLE_LEN);
  localparam int DATA_W          = 48;
  localparam int FRAC            = 30;
  localparam int GAIN_SHIFT      = 12;
  localparam int MV_W            = 16;
  localparam int RV_W            = 18;
  localparam int SUM_W           = 19;
  localparam int MA_W            = 17;
  localparam int MB_W            = 31;

  localparam logic [11:0] GAIN_RESET = 12'd102;
  localparam logic signed [MB_W-1:0] CORDIC_K = 31'sd652032874;
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;
  localparam logic signed [DATA_W-1:0] FRAC_BIAS =
    DATA_W'((48'd1 << FRAC) - 48'd1);
  localparam logic signed [DATA_W-1:0] GAIN_BIAS =
    DATA_W'((48'd1 << GAIN_SHIFT) - 48'd1);

  typedef struct packed {
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_z;
    logic               pointer_held;
    logic               click_held;
  } in_item_t;

  typedef struct packed {
    logic signed [7:0] move_x;
    logic signed [7:0] move_y;
    logic              left_button;
  } out_item_t;

  // Control word from the sequencer to the CORDIC step unit.
  typedef struct packed {
    logic              load_x;
    logic              load_y;
    logic              load_z;
    logic              step;
    logic              vectoring;
    logic [ITER_W-1:0] sh;
  } cordic_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SCALE,
    ST_VEC,
    ST_ROT,
    ST_TRUNC,
    ST_DONE
  } gtc_state_t;

  // atan(2^-i) as an unsigned 32-bit fraction of a full turn.
  function automatic logic [31:0] atan_turn(input logic [ITER_W-1:0] i);
    logic [31:0] a;
    case (i)
      5'd0:    a = 32'h2000_0000;
      5'd1:    a = 32'h12E4_051E;
      5'd2:    a = 32'h09FB_385B;
      5'd3:    a = 32'h0511_11D4;
      5'd4:    a = 32'h028B_0D43;
      5'd5:    a = 32'h0145_D7E1;
      5'd6:    a = 32'h00A2_F61E;
      5'd7:    a = 32'h0051_7C55;
      5'd8:    a = 32'h0028_BE53;
      5'd9:    a = 32'h0014_5F2F;
      5'd10:   a = 32'h000A_2F98;
      5'd11:   a = 32'h0005_17CC;
      5'd12:   a = 32'h0002_8BE6;
      5'd13:   a = 32'h0001_45F3;
      5'd14:   a = 32'h0000_A2FA;
      5'd15:   a = 32'h0000_517D;
      5'd16:   a = 32'h0000_28BE;
      5'd17:   a = 32'h0000_145F;
      5'd18:   a = 32'h0000_0A30;
      5'd19:   a = 32'h0000_0518;
      5'd20:   a = 32'h0000_028C;
      5'd21:   a = 32'h0000_0146;
      5'd22:   a = 32'h0000_00A3;
      5'd23:   a = 32'h0000_0051;
      default: a = 32'h0000_0000;
    endcase
    return a;
  endfunction

  // Clamp a signed value to the range -127 .. 127.
  function automatic logic signed [7:0] sat127(input logic signed [SUM_W-1:0] v);
    logic signed [7:0] r;
    if (v > 19'sd127) begin
      r = 8'sd127;
    end else if (v < -19'sd127) begin
      r = -8'sd127;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

/* src/gtc_mul.sv */
`timescale 1ns / 1ps

// Shared signed multiplier with a registered product.
module gtc_mul
  import gtc_pkg::*;
(
  input  logic                     clk,
  input  logic signed [MA_W-1:0]   mul_a,
  input  logic signed [MB_W-1:0]   mul_b,
  output logic signed [DATA_W-1:0] prod_r
);

  logic signed [DATA_W-1:0] prod_nxt;

  // Both operands are widened first so the full product is kept.
  assign prod_nxt = DATA_W'(mul_a) * DATA_W'(mul_b);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

/* src/gtc_cordic.sv */
`timescale 1ns / 1ps

// One CORDIC micro-rotation per cycle on the held x, y and angle registers.
// The same adders serve vectoring (drive y to zero) and rotation (drive the
// angle to zero).
module gtc_cordic
  import gtc_pkg::*;
(
  input  logic                     clk,
  input  cordic_ctl_t              ctl,
  input  logic signed [DATA_W-1:0] x_in,
  input  logic signed [DATA_W-1:0] y_in,
  input  logic [31:0]              z_in,
  output logic signed [DATA_W-1:0] x_r,
  output logic signed [DATA_W-1:0] y_r,
  output logic [31:0]              z_r
);

  logic signed [DATA_W-1:0] sx;
  logic signed [DATA_W-1:0] sy;
  logic [31:0]              ang;
  logic                     plus;
  logic signed [DATA_W-1:0] x_nxt;
  logic signed [DATA_W-1:0] y_nxt;
  logic [31:0]              z_nxt;

  always_comb begin
    sx   = x_r >>> ctl.sh;
    sy   = y_r >>> ctl.sh;
    ang  = atan_turn(ctl.sh);
    plus = ctl.vectoring ? y_r[DATA_W-1] : !z_r[31];
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    if (ctl.step) begin
      if (plus) begin
        x_nxt = x_r - sy;
        y_nxt = y_r + sx;
        z_nxt = z_r - ang;
      end else begin
        x_nxt = x_r + sy;
        y_nxt = y_r - sx;
        z_nxt = z_r + ang;
      end
    end
    if (ctl.load_x) begin
      x_nxt = x_in;
    end
    if (ctl.load_y) begin
      y_nxt = y_in;
    end
    if (ctl.load_z) begin
      z_nxt = z_in;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

endmodule

/* src/gyro_tilt_compensated_cursor.sv */
`timescale 1ns / 1ps

// Tilt-compensated gyro cursor. Each input transfer is one IMU sample and
// yields exactly one result transfer. While the pointer button is released the
// block measures the tilt angle atan2(accel_x, accel_z) with a vectoring
// CORDIC, stores it and reports zero motion; while the button is held it scales
// the three gyro rates by the gain register, rotates the negated x and z moves
// by the stored angle with a rotating CORDIC and adds the y move to the
// horizontal step. Both steps saturate to plus or minus 127 and the click
// button passes straight through. The CORDIC runs S = min(ANGLE_WIDTH, 24)
// iterations on its single step unit, which performs one micro-rotation per
// cycle; the shared multiplier forms the three gain products and the two
// CORDIC gain corrections one per cycle.
// in_stall is low only while the sequencer is idle. A finished result sits in
// the output register, so a new sample is taken while it waits; the next
// result waits in its final step until that register is free. The gain
// register should be written only while the block is idle.
`include "gyro_tilt_compensated_cursor_assert.svh"

module gyro_tilt_compensated_cursor
  import gtc_pkg::*;
#(
  parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic [11:0] cfg_wdata
);

  // The CORDIC runs no more iterations than the arctangent table holds.
  localparam int STEPS = (ANGLE_WIDTH < TABLE_LEN) ? ANGLE_WIDTH : TABLE_LEN;
  localparam logic [ITER_W-1:0] STEP_LAST = ITER_W'(STEPS - 1);
  localparam logic [31:0] ROUND_HALF = 32'd1 << (31 - ANGLE_WIDTH);

  gtc_state_t state_r, state_nxt;
  logic [ITER_W-1:0] cnt_r, cnt_nxt;
  logic [11:0] gain_r;
  logic [ANGLE_WIDTH-1:0] angle_r, angle_nxt;
  in_item_t pld_r, pld_nxt;
  logic signed [MV_W-1:0] mx_r, mx_nxt;
  logic signed [MV_W-1:0] my_r, my_nxt;
  logic signed [MV_W-1:0] mz_r, mz_nxt;
  logic signed [RV_W-1:0] rv_r, rv_nxt;
  logic signed [RV_W-1:0] rh_r, rh_nxt;
  logic out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [DATA_W-1:0] prod_r;
  logic signed [DATA_W-1:0] prod_adj;
  logic signed [MV_W-1:0]   move_c;

  cordic_ctl_t              ctl;
  logic signed [DATA_W-1:0] x_in, y_in;
  logic [31:0]              z_in;
  logic signed [DATA_W-1:0] x_r, y_r;
  logic [31:0]              z_r;

  logic signed [MA_W-1:0]   ax_ext, az_ext, vx, vy;
  logic                     az_neg;
  logic [31:0]              z_init;
  logic                     flip;
  logic signed [DATA_W-1:0] rot_v;
  logic signed [DATA_W-1:0] x_adj, y_adj;
  logic signed [SUM_W-1:0]  horiz_sum;
  logic [31:0]              z_round;
  logic                     accel_zero;

  gtc_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  gtc_cordic u_cordic (
    .clk  (clk),
    .ctl  (ctl),
    .x_in (x_in),
    .y_in (y_in),
    .z_in (z_in),
    .x_r  (x_r),
    .y_r  (y_r),
    .z_r  (z_r)
  );

  // Fixed-point helpers that feed the sequencer.
  always_comb begin
    // Axis move: rate times gain over 4096, truncated toward zero.
    prod_adj = prod_r + (prod_r[DATA_W-1] ? GAIN_BIAS : '0);
    move_c   = prod_adj[GAIN_SHIFT +: MV_W];

    // Vectoring start: a vector with negative z is turned by half a turn so
    // that the iterations only have to cover the right half-plane.
    ax_ext = {in_data.accel_x[15], in_data.accel_x};
    az_ext = {in_data.accel_z[15], in_data.accel_z};
    az_neg = in_data.accel_z[15];
    vx     = az_neg ? -az_ext : az_ext;
    vy     = az_neg ? -ax_ext : ax_ext;

    // Rotation start: an angle of a quarter turn or more is reduced by half a
    // turn and the vector negated to match.
    z_init = {angle_r, {(32 - ANGLE_WIDTH){1'b0}}};
    flip   = angle_r[ANGLE_WIDTH-1] ^ angle_r[ANGLE_WIDTH-2];
    rot_v  = flip ? -prod_r : prod_r;

    // Rotated Q30 components, truncated toward zero.
    x_adj = x_r + (x_r[DATA_W-1] ? FRAC_BIAS : '0);
    y_adj = y_r + (y_r[DATA_W-1] ? FRAC_BIAS : '0);

    horiz_sum  = SUM_W'(my_r) + SUM_W'(rh_r);
    z_round    = z_r + ROUND_HALF;
    accel_zero = (pld_r.accel_x == '0) && (pld_r.accel_z == '0);
  end

  // Sequencer: next state, operand selection and result assembly.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    angle_nxt     = angle_r;
    pld_nxt       = pld_r;
    mx_nxt        = mx_r;
    my_nxt        = my_r;
    mz_nxt        = mz_r;
    rv_nxt        = rv_r;
    rh_nxt        = rh_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    mul_a         = '0;
    mul_b         = '0;
    ctl           = '0;
    ctl.sh        = cnt_r;
    x_in          = rot_v;
    y_in          = rot_v;
    z_in          = z_init + (flip ? HALF_TURN : '0);

    case (state_r)
      ST_IDLE: begin
        x_in = {vx[MA_W-1], vx, {FRAC{1'b0}}};
        y_in = {vy[MA_W-1], vy, {FRAC{1'b0}}};
        z_in = az_neg ? HALF_TURN : '0;
        if (in_valid) begin
          pld_nxt = in_data;
          cnt_nxt = '0;
          if (in_data.pointer_held) begin
            state_nxt = ST_MUL;
          end else begin
            ctl.load_x = 1'b1;
            ctl.load_y = 1'b1;
            ctl.load_z = 1'b1;
            state_nxt  = ST_VEC;
          end
        end
      end

      // Three gain products, one per cycle; each is picked up in the cycle after it is formed.
      ST_MUL: begin
        mul_b = MB_W'(gain_r);
        case (cnt_r)
          ITER_W'(0): mul_a = MA_W'(pld_r.rate_x);
          ITER_W'(1): mul_a = MA_W'(pld_r.rate_y);
          default:    mul_a = MA_W'(pld_r.rate_z);
        endcase
        case (cnt_r)
          ITER_W'(1): mx_nxt = move_c;
          ITER_W'(2): my_nxt = move_c;
          ITER_W'(3): mz_nxt = move_c;
          default:    mx_nxt = mx_r;
        endcase
        if (cnt_r == ITER_W'(3)) begin
          cnt_nxt   = '0;
          state_nxt = ST_SCALE;
        end else begin
          cnt_nxt = cnt_r + ITER_W'(1);
        end
      end

      // Pre-scale the negated moves by the CORDIC gain and load the vector.
      ST_SCALE: begin
        mul_b = CORDIC_K;
        if (cnt_r == '0) begin
          mul_a   = -MA_W'(mx_r);
          cnt_nxt = ITER_W'(1);
        end else if (cnt_r == ITER_W'(1)) begin
          mul_a      = -MA_W'(mz_r);
          ctl.load_x = 1'b1;
          cnt_nxt    = ITER_W'(2);
        end else begin
          ctl.load_y = 1'b1;
          ctl.load_z = 1'b1;
          cnt_nxt    = '0;
          state_nxt  = ST_ROT;
        end
      end

      ST_VEC: begin
        ctl.step      = 1'b1;
        ctl.vectoring = 1'b1;
        if (cnt_r == STEP_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + ITER_W'(1);
        end
      end

      ST_ROT: begin
        ctl.step = 1'b1;
        if (cnt_r == STEP_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_TRUNC;
        end else begin
          cnt_nxt = cnt_r + ITER_W'(1);
        end
      end

      ST_TRUNC: begin
        rv_nxt    = x_adj[FRAC +: RV_W];
        rh_nxt    = y_adj[FRAC +: RV_W];
        state_nxt = ST_DONE;
      end

      // Hand the result over once the output register is free.
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.left_button = pld_r.click_held;
          if (pld_r.pointer_held) begin
            out_data_nxt.move_x = sat127(horiz_sum);
            out_data_nxt.move_y = sat127(SUM_W'(rv_r));
          end else begin
            out_data_nxt.move_x = '0;
            out_data_nxt.move_y = '0;
            angle_nxt = accel_zero ? '0 : z_round[31 -: ANGLE_WIDTH];
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      gain_r      <= GAIN_RESET;
      angle_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      angle_r     <= angle_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        gain_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    pld_r      <= pld_nxt;
    mx_r       <= mx_nxt;
    my_r       <= my_nxt;
    mz_r       <= mz_nxt;
    rv_r       <= rv_nxt;
    rh_r       <= rh_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A sample taken in must keep the block busy in the following cycle.
  `GTC_ASSERT_NXT(a_busy_after_take, clk, rst_n, in_valid && !in_stall, in_stall)
  // A new result only appears from the final step of the sequencer.
  `GTC_ASSERT_IMP(a_result_from_done, clk, rst_n, $rose(out_valid_r), $past(state_r == ST_DONE))
  // The stored tilt changes only when a released-pointer sample completes.
  `GTC_ASSERT_IMP(a_angle_update, clk, rst_n, !$stable(angle_r), $past(state_r == ST_DONE && !pld_r.pointer_held))
  // The iteration counter never runs past the arctangent table.
  `GTC_ASSERT_IMP(a_iter_bound, clk, rst_n, state_r == ST_VEC || state_r == ST_ROT, cnt_r <= STEP_LAST)

endmodule
